// ===== rtl/core/ptc_pkg.sv =====
//----------------------------------------------------------------------------
// ptc_pkg
// shared types and constants of the pps synced time counter
//----------------------------------------------------------------------------
package ptc_pkg;

    localparam int OP_W      = 2;
    localparam int BYTE_W    = 8;
    localparam int SEC_W     = 32;
    localparam int MS_W      = 11;
    localparam int US_W      = 16;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    localparam int LINE_MAX   = 126;
    localparam int LEN_W      = $clog2(LINE_MAX + 1);
    localparam int HEAD_LEN   = 7;
    localparam int HEAD_IDX_W = $clog2(HEAD_LEN);

    localparam logic [US_W-1:0] US_PER_MS_RST = US_W'(1000);
    localparam logic [MS_W-1:0] MS_LIMIT_RST  = MS_W'(1000);

    localparam logic [BYTE_W-1:0] CHAR_U  = 8'h75;
    localparam logic [BYTE_W-1:0] CHAR_T  = 8'h74;
    localparam logic [BYTE_W-1:0] CHAR_C  = 8'h63;
    localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0a;

    typedef enum logic [OP_W-1:0] {
        OP_TICK = 2'd0,
        OP_PPS  = 2'd1,
        OP_BYTE = 2'd2,
        OP_READ = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_US_PER_MS = 8'd0,
        CFG_MS_LIMIT  = 8'd1
    } cfg_idx_t;

    typedef struct packed {
        op_t               op;
        logic [BYTE_W-1:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [US_W-1:0] us_per_ms;
        logic [MS_W-1:0] ms_limit;
    } cfg_t;

    typedef struct packed {
        logic tick;
        logic pps;
    } ctl_t;

    typedef struct packed {
        logic             load;
        logic [SEC_W-1:0] value;
    } sec_load_t;

    typedef struct packed {
        logic [SEC_W-1:0] seconds;
        logic [MS_W-1:0]  millis;
        logic [US_W-1:0]  micros;
    } tod_t;

endpackage

// ===== rtl/core/ptc_if.sv =====
//----------------------------------------------------------------------------
// ptc channel interfaces
// valid/ready channels for items, results and register writes
//----------------------------------------------------------------------------
interface ptc_item_if import ptc_pkg::*;;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output op, output rx_byte, input ready);
    modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface ptc_result_if import ptc_pkg::*;;
    logic             valid;
    logic             ready;
    logic [SEC_W-1:0] seconds;
    logic [MS_W-1:0]  millis;
    logic [US_W-1:0]  micros;

    modport source (output valid, output seconds, output millis, output micros, input ready);
    modport sink   (input valid, input seconds, input millis, input micros, output ready);
endinterface

interface ptc_cfg_if import ptc_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] addr;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

// ===== rtl/core/ptc_cfg_regs.sv =====
//----------------------------------------------------------------------------
// ptc_cfg_regs
// period and millisecond limit registers
//----------------------------------------------------------------------------
module ptc_cfg_regs
    import ptc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ptc_cfg_if.sink   cfg,
    output cfg_t      cfg_val
);

    cfg_t cfg_reg;

    assign cfg.ready = 1'b1;
    assign cfg_val   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.us_per_ms <= US_PER_MS_RST;
            cfg_reg.ms_limit  <= MS_LIMIT_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.addr)
                CFG_US_PER_MS: cfg_reg.us_per_ms <= cfg.data[US_W-1:0];
                CFG_MS_LIMIT:  cfg_reg.ms_limit  <= cfg.data[MS_W-1:0];
                default:       ;
            endcase
        end
    end

endmodule

// ===== rtl/core/ptc_in_reg.sv =====
//----------------------------------------------------------------------------
// ptc_in_reg
// input register holding one item until it is processed
//----------------------------------------------------------------------------
module ptc_in_reg
    import ptc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ptc_item_if.sink  item,
    input  logic      advance,
    output logic      vld,
    output item_t     data
);

    logic  valid_reg;
    item_t data_reg;

    assign item.ready = !valid_reg || advance;
    assign vld        = valid_reg;
    assign data       = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (item.valid && item.ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            data_reg.op      <= op_t'(item.op);
            data_reg.rx_byte <= item.rx_byte;
        end
    end

endmodule

// ===== rtl/core/ptc_line_parser.sv =====
//----------------------------------------------------------------------------
// ptc_line_parser
// collects serial bytes into a line and decodes the utc seconds message
//----------------------------------------------------------------------------
module ptc_line_parser
    import ptc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_en,
    input  logic [BYTE_W-1:0] rx_byte,
    output sec_load_t         sec_load
);

    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_next;
    logic [BYTE_W-1:0] head_reg [HEAD_LEN];
    logic              is_lf;
    logic              head_wr;
    logic              hdr_ok;

    assign is_lf   = (rx_byte == CHAR_LF);
    assign head_wr = byte_en && !is_lf && (len_reg < LEN_W'(HEAD_LEN));
    assign hdr_ok  = (len_reg >= LEN_W'(HEAD_LEN)) && (head_reg[0] == CHAR_U)
                     && (head_reg[1] == CHAR_T) && (head_reg[2] == CHAR_C);

    assign sec_load.load  = byte_en && is_lf && hdr_ok;
    assign sec_load.value = {head_reg[3], head_reg[4], head_reg[5], head_reg[6]};

    always_comb
    begin
        len_next = len_reg;
        if (byte_en)
        begin
            if (is_lf)
            begin
                len_next = '0;
            end
            else if (len_reg < LEN_W'(LINE_MAX))
            begin
                len_next = len_reg + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_wr)
        begin
            head_reg[len_reg[HEAD_IDX_W-1:0]] <= rx_byte;
        end
    end

endmodule

// ===== rtl/core/ptc_tod_counter.sv =====
//----------------------------------------------------------------------------
// ptc_tod_counter
// microsecond, millisecond and seconds counters
//----------------------------------------------------------------------------
module ptc_tod_counter
    import ptc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg_val,
    input  ctl_t      ctl,
    input  sec_load_t sec_load,
    output tod_t      tod
);

    logic [US_W-1:0]  us_reg;
    logic [US_W-1:0]  us_next;
    logic [MS_W-1:0]  ms_reg;
    logic [MS_W-1:0]  ms_next;
    logic [SEC_W-1:0] sec_reg;
    logic [SEC_W-1:0] sec_next;
    logic [US_W:0]    us_inc;
    logic             us_wrap;
    logic             ms_sat;

    assign us_inc  = {1'b0, us_reg} + (US_W + 1)'(1);
    assign us_wrap = (us_inc >= {1'b0, cfg_val.us_per_ms});
    assign ms_sat  = (ms_reg >= cfg_val.ms_limit);

    always_comb
    begin
        us_next  = us_reg;
        ms_next  = ms_reg;
        sec_next = sec_reg;
        if (ctl.tick)
        begin
            if (us_wrap)
            begin
                us_next = '0;
                ms_next = ms_sat ? cfg_val.ms_limit : ms_reg + MS_W'(1);
            end
            else
            begin
                us_next = us_inc[US_W-1:0];
            end
        end
        if (ctl.pps)
        begin
            us_next  = '0;
            ms_next  = '0;
            sec_next = sec_reg + SEC_W'(1);
        end
        if (sec_load.load)
        begin
            sec_next = sec_load.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            us_reg  <= '0;
            ms_reg  <= '0;
            sec_reg <= '0;
        end
        else
        begin
            us_reg  <= us_next;
            ms_reg  <= ms_next;
            sec_reg <= sec_next;
        end
    end

    assign tod.seconds = sec_reg;
    assign tod.millis  = (ms_reg > cfg_val.ms_limit) ? cfg_val.ms_limit : ms_reg;
    assign tod.micros  = us_reg;

endmodule

// ===== rtl/core/ptc_out_reg.sv =====
//----------------------------------------------------------------------------
// ptc_out_reg
// result register holding a time snapshot until it is taken
//----------------------------------------------------------------------------
module ptc_out_reg
    import ptc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  tod_t         tod,
    output logic         free,
    ptc_result_if.source result
);

    logic valid_reg;
    tod_t data_reg;

    assign free           = !valid_reg || result.ready;
    assign result.valid   = valid_reg;
    assign result.seconds = data_reg.seconds;
    assign result.millis  = data_reg.millis;
    assign result.micros  = data_reg.micros;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= tod;
        end
    end

endmodule

// ===== rtl/core/pps_synced_time_counter.sv =====
//----------------------------------------------------------------------------
// pps_synced_time_counter
// Time of day counter disciplined by a pulse-per-second input. It takes one
// item per clock cycle: ticks, pulses and serial bytes update the counters in
// the cycle after they are accepted, and a read item captures its time
// snapshot in the result register once that register is free. The only
// thing that holds the input back is a read meeting a full result register
// that is not being taken; other items keep flowing past a waiting result.
// Configuration writes are taken at any time and are registered before use.
//----------------------------------------------------------------------------
module pps_synced_time_counter
    import ptc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    ptc_item_if.sink     item,
    ptc_cfg_if.sink      cfg,
    ptc_result_if.source result
);

    logic      in_vld;
    item_t     in_data;
    logic      out_free;
    logic      advance;
    cfg_t      cfg_val;
    ctl_t      ctl;
    sec_load_t sec_load;
    tod_t      tod;
    logic      byte_en;
    logic      read_en;

    assign advance  = in_vld && ((in_data.op != OP_READ) || out_free);
    assign ctl.tick = advance && (in_data.op == OP_TICK);
    assign ctl.pps  = advance && (in_data.op == OP_PPS);
    assign byte_en  = advance && (in_data.op == OP_BYTE);
    assign read_en  = advance && (in_data.op == OP_READ);

    ptc_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_val (cfg_val)
    );

    ptc_in_reg u_in_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .advance (advance),
        .vld     (in_vld),
        .data    (in_data)
    );

    ptc_line_parser u_line_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_en  (byte_en),
        .rx_byte  (in_data.rx_byte),
        .sec_load (sec_load)
    );

    ptc_tod_counter u_tod_counter (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_val  (cfg_val),
        .ctl      (ctl),
        .sec_load (sec_load),
        .tod      (tod)
    );

    ptc_out_reg u_out_reg (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (read_en),
        .tod    (tod),
        .free   (out_free),
        .result (result)
    );

endmodule
